// ===== rtl/rcf_pkg.sv =====
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared types, codes and helpers for the RGB convolution filter.
// ----------------------------------------------------------------------------
package rcf_pkg;

  localparam int PIX_W  = 24;
  localparam int CH_W   = 8;
  localparam int COEF_W = 16;
  localparam int ACC_W  = 32;
  localparam int CH_MAX = 255;
  localparam int FRAC_W = 8;

  typedef enum logic [1:0] {
    ACT_COEF  = 2'd0,
    ACT_PIXEL = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHK   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  typedef struct packed {
    logic clr;
    logic en;
  } cell_ctl_t;

  function automatic logic [CH_W-1:0] clamp_ch(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] q;
    q = a >>> FRAC_W;
    if (a < 0) begin
      return '0;
    end else if (q > CH_MAX) begin
      return CH_W'(CH_MAX);
    end else begin
      return q[CH_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/rcf_ram.sv =====
// ----------------------------------------------------------------------------
// rcf_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rcf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rcf_cell.sv =====
// ----------------------------------------------------------------------------
// rcf_cell
// MAC cell: accumulates coef times the top byte of the pixel word, then
// hands coef, the shifted pixel word and control to the next cell.
// ----------------------------------------------------------------------------
module rcf_cell import rcf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_ctl_t                ctl_in,
  input  logic signed [COEF_W-1:0] coef_in,
  input  logic [PIX_W-1:0]         pix_in,
  output cell_ctl_t                ctl_out,
  output logic signed [COEF_W-1:0] coef_out,
  output logic [PIX_W-1:0]         pix_out,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [COEF_W+CH_W:0] prod;
  logic signed [ACC_W-1:0]     acc_r, acc_nxt;
  cell_ctl_t                   ctl_r;
  logic signed [COEF_W-1:0]    coef_r;
  logic [PIX_W-1:0]            pix_r;

  assign prod = coef_in * $signed({1'b0, pix_in[PIX_W-1 -: CH_W]});

  always_comb begin
    acc_nxt = acc_r;
    if (ctl_in.clr) begin
      acc_nxt = '0;
    end else if (ctl_in.en) begin
      acc_nxt = acc_r + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    coef_r <= coef_in;
    pix_r  <= pix_in << CH_W;
  end

  assign ctl_out  = ctl_r;
  assign coef_out = coef_r;
  assign pix_out  = pix_r;
  assign acc      = acc_r;

endmodule

// ===== rtl/rgb_convolution_filter_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_convolution_filter_unit
// Streaming zero-padded 2-D convolution of an RGB image in raster order.
//
// Input channel (in_valid / in_stall): one item per handshake. action selects
// a coefficient load, a pixel, or a flush. A pixel or flush item stalls the
// input while the unit checks whether an output pixel is ready and, if one
// is, while it scans the (2R+1)^2 taps, R being the kernel radius: the taps
// are fetched one per cycle through the single read port of the line memory
// and go down a chain of three MAC cells, one per color channel. The sums are
// then drained from the chain, clamped and registered as the filtered pixel.
// Output channel (out_valid / out_stall): at most one pixel per item; it is
// held while out_stall is high. Items are still taken meanwhile; the next
// output pixel waits in its final step until the held one is gone.
// Config port: cfg_we writes register cfg_index (0 width, 1 height,
// 2 radius) and restarts the frame; write only while idle.
// Reset: geometry returns to width 1024, height 1, radius 1, positions to
// zero. Line and kernel memories are not cleared; load every coefficient of
// the kernel before streaming pixels.
// ----------------------------------------------------------------------------
module rgb_convolution_filter_unit import rcf_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_action,
  input  logic [5:0]               in_coef_index,
  input  logic signed [COEF_W-1:0] in_coef_value,
  input  logic [CH_W-1:0]          in_red_in,
  input  logic [CH_W-1:0]          in_green_in,
  input  logic [CH_W-1:0]          in_blue_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CH_W-1:0]          out_red_out,
  output logic [CH_W-1:0]          out_green_out,
  output logic [CH_W-1:0]          out_blue_out,
  output logic                     out_frame_end,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [15:0]              cfg_wdata
);

  localparam int KSIZE  = 2 * MAX_RADIUS + 1;
  localparam int KDEPTH = KSIZE * KSIZE;
  localparam int SLOTS  = 2 * MAX_RADIUS + 2;
  localparam int LDEPTH = SLOTS * MAX_WIDTH;
  localparam int LAW    = $clog2(LDEPTH);
  localparam int KAW    = $clog2(KDEPTH);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = CW + 1;
  localparam int SW     = $clog2(SLOTS);
  localparam int SSW    = $clog2(3 * SLOTS);
  localparam int RW     = $clog2(MAX_RADIUS + 1);
  localparam int TW     = $clog2(KSIZE);
  localparam int HW     = 16;
  localparam int NCELL  = 3;

  // configuration
  logic [10:0]   image_width_r;
  logic [HW-1:0] image_height_r;
  logic [1:0]    kernel_radius_r;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [RW-1:0] r_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= 11'd1024;
      image_height_r  <= 16'd1;
      kernel_radius_r <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width_r   <= cfg_wdata[10:0];
        REG_HEIGHT: image_height_r  <= cfg_wdata;
        REG_RADIUS: kernel_radius_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(image_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width_r);
    end
    h_eff = (image_height_r == '0) ? HW'(1) : image_height_r;
    if (32'(kernel_radius_r) > MAX_RADIUS) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(kernel_radius_r);
    end
  end

  // control state
  state_t           state_r, state_nxt;
  logic [HW-1:0]    in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [CW-1:0]    in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [SW-1:0]    in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic [TW-1:0]    dr_r, dr_nxt, dc_r, dc_nxt;
  logic [1:0]       drain_r, drain_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             clr_r, tap_v_r;
  logic [CH_W-1:0]  red_r, green_r, blue_r;
  logic             frame_end_r;

  logic             in_acc, pix_we, coef_we, ready, scan_last, last_px, tap_v;
  logic             fin_go;
  logic [WW-1:0]    in_col_inc, out_col_inc;
  logic [HW:0]      rsum, rmax;
  logic [WW:0]      csum, cmax;
  logic signed [HW+1:0] tr;
  logic signed [CW+2:0] tc;
  logic [SSW-1:0]   ssum;
  logic [SW-1:0]    tslot;
  logic [LAW-1:0]   l_waddr, l_raddr;
  logic [KAW-1:0]   k_raddr;
  logic [PIX_W-1:0] l_rdata;
  logic [COEF_W-1:0] k_rdata;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign pix_we   = in_acc && (in_action == ACT_PIXEL) && (in_row_r < h_eff);
  assign coef_we  = in_acc && (in_action == ACT_COEF) && (32'(in_coef_index) < KDEPTH);
  assign l_waddr  = LAW'(32'(in_slot_r) * MAX_WIDTH) + LAW'(in_col_r);
  // final step waits while the previous pixel is still held
  assign fin_go   = (state_r == S_FIN) && !(out_valid_r && out_stall);

  // readiness of the next output pixel
  always_comb begin
    rsum = {1'b0, out_row_r} + (HW+1)'(r_eff);
    rmax = (rsum > {1'b0, h_eff} - 1'b1) ? {1'b0, h_eff} - 1'b1 : rsum;
    csum = {2'b0, out_col_r} + (WW+1)'(r_eff);
    cmax = (csum > {1'b0, w_eff} - 1'b1) ? {1'b0, w_eff} - 1'b1 : csum;
    ready = (out_row_r < h_eff) &&
            ((in_row_r >= h_eff) || ({1'b0, in_row_r} > rmax) ||
             ({1'b0, in_row_r} == rmax && (WW+1)'(in_col_r) > cmax));
  end

  // tap address generation
  always_comb begin
    tr = (HW+2)'(out_row_r) + (HW+2)'(dr_r) - (HW+2)'(r_eff);
    tc = (CW+3)'(out_col_r) + (CW+3)'(dc_r) - (CW+3)'(r_eff);
    tap_v = (state_r == S_SCAN) && !tr[HW+1] && (tr[HW:0] < {1'b0, h_eff}) &&
            !tc[CW+2] && (tc[CW+1:0] < (CW+2)'(w_eff));
    ssum = SSW'(out_slot_r) + SSW'(dr_r) + SSW'(SLOTS) - SSW'(r_eff);
    if (32'(ssum) >= 2 * SLOTS) begin
      tslot = SW'(ssum - SSW'(2 * SLOTS));
    end else if (32'(ssum) >= SLOTS) begin
      tslot = SW'(ssum - SSW'(SLOTS));
    end else begin
      tslot = SW'(ssum);
    end
    l_raddr = LAW'(32'(tslot) * MAX_WIDTH) + LAW'(tc[CW-1:0]);
    k_raddr = KAW'(32'(dr_r) * KSIZE + 32'(dc_r));
    scan_last = (32'(dr_r) == 2 * 32'(r_eff)) && (32'(dc_r) == 2 * 32'(r_eff));
    last_px = (out_row_r == h_eff - 1'b1) && ({1'b0, out_col_r} == w_eff - 1'b1);
    in_col_inc  = {1'b0, in_col_r} + 1'b1;
    out_col_inc = {1'b0, out_col_r} + 1'b1;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    dr_nxt        = dr_r;
    dc_nxt        = dc_r;
    drain_nxt     = drain_r;
    in_row_nxt    = in_row_r;
    in_col_nxt    = in_col_r;
    in_slot_nxt   = in_slot_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_slot_nxt  = out_slot_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_action == ACT_PIXEL || in_action == ACT_FLUSH)) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        dr_nxt    = '0;
        dc_nxt    = '0;
        state_nxt = ready ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        if (scan_last) begin
          drain_nxt = 2'd2;
          state_nxt = S_DRAIN;
        end else if (32'(dc_r) == 2 * 32'(r_eff)) begin
          dc_nxt = '0;
          dr_nxt = dr_r + 1'b1;
        end else begin
          dc_nxt = dc_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (drain_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          drain_nxt = drain_r - 1'b1;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (!last_px) begin
            if (out_col_inc >= w_eff) begin
              out_col_nxt  = '0;
              out_row_nxt  = out_row_r + 1'b1;
              out_slot_nxt = (32'(out_slot_r) == SLOTS - 1) ? '0 : out_slot_r + 1'b1;
            end else begin
              out_col_nxt = out_col_inc[CW-1:0];
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (pix_we) begin
      if (in_col_inc >= w_eff) begin
        in_col_nxt  = '0;
        in_row_nxt  = in_row_r + 1'b1;
        in_slot_nxt = (32'(in_slot_r) == SLOTS - 1) ? '0 : in_slot_r + 1'b1;
      end else begin
        in_col_nxt = in_col_inc[CW-1:0];
      end
    end

    if ((cfg_we && (cfg_index inside {REG_WIDTH, REG_HEIGHT, REG_RADIUS})) ||
        (fin_go && last_px)) begin
      in_row_nxt   = '0;
      in_col_nxt   = '0;
      in_slot_nxt  = '0;
      out_row_nxt  = '0;
      out_col_nxt  = '0;
      out_slot_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dr_r        <= '0;
      dc_r        <= '0;
      drain_r     <= '0;
      in_row_r    <= '0;
      in_col_r    <= '0;
      in_slot_r   <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_slot_r  <= '0;
      out_valid_r <= 1'b0;
      clr_r       <= 1'b0;
      tap_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dr_r        <= dr_nxt;
      dc_r        <= dc_nxt;
      drain_r     <= drain_nxt;
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      in_slot_r   <= in_slot_nxt;
      out_row_r   <= out_row_nxt;
      out_col_r   <= out_col_nxt;
      out_slot_r  <= out_slot_nxt;
      out_valid_r <= out_valid_nxt;
      clr_r       <= (state_r == S_CHK) && ready;
      tap_v_r     <= tap_v;
    end
  end

  // memories
  rcf_ram #(.WIDTH(PIX_W), .DEPTH(LDEPTH)) u_line_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (l_waddr),
    .wdata ({in_red_in, in_green_in, in_blue_in}),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  rcf_ram #(.WIDTH(COEF_W), .DEPTH(KDEPTH)) u_kernel_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (KAW'(in_coef_index)),
    .wdata (in_coef_value),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  // MAC chain: red, green, blue
  cell_ctl_t               ctl_c  [NCELL+1];
  logic signed [COEF_W-1:0] coef_c [NCELL+1];
  logic [PIX_W-1:0]        pix_c  [NCELL+1];
  logic signed [ACC_W-1:0] acc_c  [NCELL];

  assign ctl_c[0]  = '{clr: clr_r, en: tap_v_r};
  assign coef_c[0] = $signed(k_rdata);
  assign pix_c[0]  = l_rdata;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    rcf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_in   (ctl_c[g]),
      .coef_in  (coef_c[g]),
      .pix_in   (pix_c[g]),
      .ctl_out  (ctl_c[g+1]),
      .coef_out (coef_c[g+1]),
      .pix_out  (pix_c[g+1]),
      .acc      (acc_c[g])
    );
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      red_r       <= clamp_ch(acc_c[0]);
      green_r     <= clamp_ch(acc_c[1]);
      blue_r      <= clamp_ch(acc_c[2]);
      frame_end_r <= last_px;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = red_r;
  assign out_green_out = green_r;
  assign out_blue_out  = blue_r;
  assign out_frame_end = frame_end_r;

  // checks
  a_fin_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("output raised without a finished sum");

  a_scan_row: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> out_row_r < h_eff)
    else $error("scan on a row outside the image");

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan_last) |=> state_r == S_DRAIN)
    else $error("scan did not end in drain");

  a_chain_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !tap_v)
    else $error("tap issued while idle");

endmodule

// ===== test/tb_rgb_convolution_filter_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_convolution_filter_unit
// Streams coefficient loads, pixels and flushes through the filter under
// random idling on both channels, across many image geometries and kernel
// radii. A local predictor of the convolution produces the expected pixels,
// which are compared in order with the output channel.
// ----------------------------------------------------------------------------
module tb_rgb_convolution_filter_unit;
  import rcf_pkg::*;

  localparam int TB_MAX_W   = 1024;
  localparam int TB_MAX_R   = 3;
  localparam int KSZ        = 2 * TB_MAX_R + 1;
  localparam int KTAPS      = KSZ * KSZ;
  localparam int SLOTS      = 2 * TB_MAX_R + 2;
  localparam int CYCLE_CAP  = 3000000;
  localparam int ITEM_GOAL  = 1950;

  typedef struct packed {
    action_t                  act;
    logic [5:0]               idx;
    logic signed [COEF_W-1:0] coef;
    logic [CH_W-1:0]          r;
    logic [CH_W-1:0]          g;
    logic [CH_W-1:0]          b;
  } feed_item_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic            fe;
  } out_pix_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_action;
  logic [5:0] in_coef_index;
  logic signed [COEF_W-1:0] in_coef_value;
  logic [CH_W-1:0] in_red_in, in_green_in, in_blue_in;
  logic out_valid, out_stall;
  logic [CH_W-1:0] out_red_out, out_green_out, out_blue_out;
  logic out_frame_end;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_wdata;

  rgb_convolution_filter_unit dut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic [PIX_W-1:0] line_mem [0:SLOTS*TB_MAX_W-1];
  logic signed [COEF_W-1:0] kern [0:KTAPS-1];
  int unsigned in_row, in_col, out_row, out_col;
  int unsigned geo_w, geo_h, geo_r;

  feed_item_t pending_items[$];
  out_pix_t   expected_pixels[$];

  int send_idle_pct = 22;
  int recv_idle_pct = 81;
  int items_fed, pixels_seen, frames_seen, reg_writes, errors, cycles;

  function automatic int unsigned eff_w();
    return geo_w < 1 ? 1 : (geo_w > TB_MAX_W ? TB_MAX_W : geo_w);
  endfunction

  function automatic int unsigned eff_h();
    return geo_h == 0 ? 1 : geo_h;
  endfunction

  function automatic int unsigned eff_r();
    return geo_r > TB_MAX_R ? TB_MAX_R : geo_r;
  endfunction

  function automatic logic [CH_W-1:0] sat_ch(longint s);
    longint v;
    if (s < 0) return '0;
    v = s / 256;
    return v > 255 ? 8'd255 : v[7:0];
  endfunction

  task automatic try_emit_pixel();
    int unsigned w, h, rad, rmax, cmax, idx;
    int rr, cc;
    longint acc_r, acc_g, acc_b, k;
    logic [PIX_W-1:0] p;
    out_pix_t o;
    w = eff_w(); h = eff_h(); rad = eff_r();
    acc_r = 0; acc_g = 0; acc_b = 0;
    if (out_row >= h) return;
    if (in_row < h) begin
      rmax = (out_row + rad > h - 1) ? h - 1 : out_row + rad;
      cmax = (out_col + rad > w - 1) ? w - 1 : out_col + rad;
      if (!(in_row > rmax || (in_row == rmax && in_col > cmax))) return;
    end
    for (int dr = 0; dr <= 2 * rad; dr++) begin
      rr = int'(out_row) + dr - int'(rad);
      if (rr < 0 || rr >= int'(h)) continue;
      for (int dc = 0; dc <= 2 * rad; dc++) begin
        cc = int'(out_col) + dc - int'(rad);
        if (cc < 0 || cc >= int'(w)) continue;
        idx = (rr % SLOTS) * TB_MAX_W + cc;
        p = line_mem[idx];
        k = kern[dr * KSZ + dc];
        acc_r += k * longint'(p[23:16]);
        acc_g += k * longint'(p[15:8]);
        acc_b += k * longint'(p[7:0]);
      end
    end
    o.r = sat_ch(acc_r); o.g = sat_ch(acc_g); o.b = sat_ch(acc_b);
    o.fe = (out_row == h - 1) && (out_col == w - 1);
    expected_pixels.push_back(o);
    if (o.fe) begin
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  task automatic filter_step(feed_item_t it);
    case (it.act)
      ACT_COEF: if (it.idx < KTAPS) kern[it.idx] = it.coef;
      ACT_PIXEL: begin
        if (in_row < eff_h() && in_col < eff_w()) begin
          line_mem[(in_row % SLOTS) * TB_MAX_W + in_col] = {it.r, it.g, it.b};
          in_col++;
          if (in_col >= eff_w()) begin
            in_col = 0;
            in_row++;
          end
        end
        try_emit_pixel();
      end
      ACT_FLUSH: try_emit_pixel();
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin : drive_items
    feed_item_t it, held;
    bit busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        held.act = action_t'(in_action);
        held.idx = in_coef_index;
        held.coef = in_coef_value;
        held.r = in_red_in; held.g = in_green_in; held.b = in_blue_in;
        filter_step(held);
        items_fed++;
        if (items_fed == ITEM_GOAL / 3) begin
          send_idle_pct = 81;
          recv_idle_pct = 22;
        end else if (items_fed == 2 * ITEM_GOAL / 3) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_items.pop_front();
          in_valid <= 1'b1;
          in_action <= it.act;
          in_coef_index <= it.idx;
          in_coef_value <= it.coef;
          in_red_in <= it.r;
          in_green_in <= it.g;
          in_blue_in <= it.b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_pixels
    out_pix_t e;
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel r=%0d g=%0d b=%0d fe=%0d", $time,
                 out_red_out, out_green_out, out_blue_out, out_frame_end);
      end else begin
        e = expected_pixels.pop_front();
        if (e.fe) frames_seen++;
        if ({out_red_out, out_green_out, out_blue_out, out_frame_end} !== e) begin
          errors++;
          $display("%0t: mismatch exp r=%0d g=%0d b=%0d fe=%0d act r=%0d g=%0d b=%0d fe=%0d",
                   $time, e.r, e.g, e.b, e.fe,
                   out_red_out, out_green_out, out_blue_out, out_frame_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_item(action_t a, int unsigned idx, int unsigned coef,
                           int unsigned r, int unsigned g, int unsigned b);
    feed_item_t it;
    it.act = a; it.idx = 6'(idx); it.coef = 16'(coef);
    it.r = 8'(r); it.g = 8'(g); it.b = 8'(b);
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 16'(val);
    case (idx)
      REG_WIDTH:  geo_w = val[10:0];
      REG_HEIGHT: geo_h = val[15:0];
      REG_RADIUS: geo_r = val[1:0];
      default: ;
    endcase
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    reg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(int w, int h, int r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIUS, r);
  endtask

  // mode 0: modest taps, 1: full range, 2: single center tap
  task automatic load_kernel(int mode, logic [15:0] center);
    logic [15:0] v;
    for (int i = 0; i < KTAPS; i++) begin
      case (mode)
        0: v = 16'($signed($urandom_range(256)) - 96);
        1: v = 16'($urandom_range(16'hffff));
        default: v = (i == TB_MAX_R * KSZ + TB_MAX_R) ? center : 16'h0000;
      endcase
      push_item(ACT_COEF, i, v, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic queue_frame(int rows, bit extremes);
    int n;
    logic [7:0] r, g, b;
    n = rows * eff_w();
    for (int i = 0; i < n; i++) begin
      if (extremes) begin
        r = $urandom_range(1) ? 8'hff : 8'h00;
        g = $urandom_range(1) ? 8'hff : 8'h00;
        b = $urandom_range(1) ? 8'hff : 8'h00;
      end else begin
        r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      end
      push_item(ACT_PIXEL, $urandom, $urandom, r, g, b);
      case ($urandom_range(39))
        0: push_item(ACT_FLUSH, $urandom, $urandom, $urandom, $urandom, $urandom);
        1: push_item(ACT_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
        2: push_item(ACT_COEF, $urandom_range(63, KTAPS), $urandom, $urandom,
                     $urandom, $urandom);
        default: ;
      endcase
    end
    // drain; some pixels land while outputs are still pending
    n = eff_r() * eff_w() + eff_r() + 2;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0)
        push_item(ACT_PIXEL, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        push_item(ACT_FLUSH, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    int step, w, h, r;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_WIDTH; cfg_wdata = '0;
    in_action = ACT_NONE; in_coef_index = '0; in_coef_value = '0;
    in_red_in = '0; in_green_in = '0; in_blue_in = '0;
    geo_w = 1024; geo_h = 1; geo_r = 1;
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    load_kernel(2, 16'h7fff);
    push_item(ACT_COEF, 6'd63, 16'h8000, 8'hff, 8'hff, 8'hff);
    push_item(ACT_NONE, 6'h3f, 16'hffff, 8'hff, 8'hff, 8'hff);
    push_item(ACT_FLUSH, 6'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
    set_geometry(3, 2, 1);
    queue_frame(2, 1);
    push_item(ACT_COEF, TB_MAX_R * KSZ + TB_MAX_R, 16'h8000, 0, 0, 0);
    queue_frame(2, 1);
    wait_drained();
    load_kernel(1, 0);
    set_geometry(2047, 1, 0);
    queue_frame(1, 0);
    set_geometry(0, 0, 3);
    queue_frame(1, 1);
    set_geometry(1, 4, 3);
    queue_frame(4, 0);
    set_geometry(4, 65535, 2);
    queue_frame(3, 0);

    // random
    step = 0;
    while (items_fed + pending_items.size() < ITEM_GOAL) begin
      w = $urandom_range(3) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 12);
      h = $urandom_range(1, 6);
      r = $urandom_range(3);
      if (step % 3 == 0) begin
        set_geometry(w, h, r);
      end else begin
        case ($urandom_range(2))
          0: write_reg(REG_WIDTH, w);
          1: write_reg(REG_HEIGHT, h);
          default: write_reg(REG_RADIUS, r);
        endcase
      end
      if (step % 4 == 0) load_kernel($urandom_range(3) == 0, 0);
      queue_frame(eff_h(), $urandom_range(7) == 0);
      if ($urandom_range(1)) queue_frame(eff_h(), 0);
      wait_drained();
      step++;
    end

    wait_drained();
    repeat (100) @(posedge clk);
    $display("Fed %0d items over %0d register writes; checked %0d pixels, %0d frames.",
             items_fed, reg_writes, pixels_seen, frames_seen);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
